>>> rtl/psd_pkg.sv
// ============================================================================
// psd_pkg: shared types and constants of the planar smooth damp block
// Fixed point formats, payload structs, step codes and helper functions.
// ============================================================================
`default_nettype none

package psd_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;
    localparam int WIDE_BITS = 68;

    localparam int ST_W = 25;
    localparam int MS_W = 31;
    localparam int TK_W = 17;
    localparam int CFG_DATA_W = 31;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH_TIME = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_TIME   = 2'd2;

    localparam logic [ST_W-1:0] ST_RESET = 25'd19661;
    localparam logic [MS_W-1:0] MS_RESET = 31'h7FFF_FFFF;
    localparam logic [TK_W-1:0] TK_RESET = 17'd1092;

    localparam longint ONE_L = longint'(1) << FRAC_BITS;
    localparam logic [63:0] ONE = 64'(ONE_L);
    localparam logic [ST_W-1:0] ST_MIN = ST_W'((ONE_L + 5000) / 10000);
    localparam logic [63:0] C2 = 64'((12 * ONE_L + 12) / 25);
    localparam logic [63:0] C3 = 64'((47 * ONE_L + 100) / 200);
    localparam logic [63:0] X_CAP = ONE << 8;
    localparam logic [63:0] RATE_NUM = 64'(2) << (2 * FRAC_BITS);
    localparam logic [63:0] DK_NUM = 64'(1) << (2 * FRAC_BITS);

    typedef struct packed {
        logic signed [WORD_BITS-1:0] current_x;
        logic signed [WORD_BITS-1:0] current_y;
        logic signed [WORD_BITS-1:0] target_x;
        logic signed [WORD_BITS-1:0] target_y;
    } t_in_item;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] next_x;
        logic signed [WORD_BITS-1:0] next_y;
    } t_out_item;

    typedef enum logic [1:0] {
        AOP_MUL,
        AOP_DIV,
        AOP_SQRT
    } t_aop;

    typedef enum logic [4:0] {
        P_RATE, P_X, P_X2, P_X3, P_T2, P_T3, P_DK,
        P_LIM, P_LIM2, P_DX2, P_DY2,
        P_SQRT, P_QXM, P_QXD, P_QYM, P_QYD,
        P_OMDX, P_NX, P_OMNX, P_VX, P_OX,
        P_OMDY, P_NY, P_OMNY, P_VY, P_OY,
        P_DOTX, P_DOTY
    } t_step;

    typedef struct packed {
        logic  go;
        t_step step;
        logic  load;
        logic  commit;
    } t_cmd;

    typedef struct packed {
        logic done;
        logic clamp;
        logic cfg_hit;
        logic out_busy;
    } t_status;

    function automatic logic signed [WIDE_BITS-1:0] apply_sign(input logic neg,
                                                               input logic [63:0] m);
        logic signed [WIDE_BITS-1:0] v;
        v = $signed(WIDE_BITS'(m));
        return neg ? -v : v;
    endfunction

    function automatic logic [63:0] mag_wide(input logic signed [WIDE_BITS-1:0] v);
        return v[WIDE_BITS-1] ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic signed [WORD_BITS-1:0] sat_word(
        input logic signed [WIDE_BITS-1:0] v);
        logic signed [WIDE_BITS-1:0] hi;
        logic signed [WIDE_BITS-1:0] lo;
        hi = WIDE_BITS'({1'b0, {(WORD_BITS-1){1'b1}}});
        lo = -hi - WIDE_BITS'(1);
        if (v > hi) begin
            return hi[WORD_BITS-1:0];
        end else if (v < lo) begin
            return lo[WORD_BITS-1:0];
        end
        return v[WORD_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

>>> rtl/psd_in_if.sv
// ============================================================================
// psd_in_if: input channel of the planar smooth damp block
// Valid and ready handshake that carries one position and target pair.
// ============================================================================
`default_nettype none

interface psd_in_if
    import psd_pkg::*;
();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/psd_out_if.sv
// ============================================================================
// psd_out_if: output channel of the planar smooth damp block
// Valid and ready handshake that carries one smoothed position.
// ============================================================================
`default_nettype none

interface psd_out_if
    import psd_pkg::*;
();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/planar_smooth_damp.sv
// ============================================================================
// planar_smooth_damp: critically damped spring smoothing in two dimensions
// Gives the next position toward a target and keeps a velocity per tick.
// ============================================================================
// Usage: each transfer on i_in carries a current and a target position in
// signed Q16.16; each produces exactly one transfer on o_out with the smoothed
// position. Configuration registers are written through i_cfg_we, i_cfg_idx
// and i_cfg_data while no item is in flight.
// One shared arithmetic unit does every step, and the steps run one after another;
// an item whose offset is clamped runs more steps than one that is not.
// After reset and after every write to a configuration register the spring rate
// and decay factor are recomputed, during which i_in is not ready.
// Reset clears the velocity, loads the default configuration and drops any
// pending result. A finished result waits in the output register while the
// receiver stalls; the next item is still taken and worked on, and it is held
// at its end until the waiting result has been transferred.
// ============================================================================
`default_nettype none

module planar_smooth_damp
    import psd_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    psd_in_if.sink                     i_in,
    psd_out_if.source                  o_out
);

    t_cmd    cmd;
    t_status status;

    psd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    psd_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_in_data   (i_in.data),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_out_data  (o_out.data)
    );

endmodule

`default_nettype wire

>>> rtl/psd_arith.sv
// ============================================================================
// psd_arith: shared iterative arithmetic unit
// Multiply 8 bits a cycle, divide and square root one digit a cycle.
// ============================================================================
`default_nettype none

module psd_arith
    import psd_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire t_aop         i_op,
    input  wire logic [63:0]  i_a,
    input  wire logic [63:0]  i_b,
    output logic              o_done,
    output logic [127:0]      o_res
);

    logic         r_busy;
    logic         r_done;
    t_aop         r_op;
    logic [5:0]   r_cnt;
    logic [127:0] r_acc;
    logic [63:0]  r_a;
    logic [63:0]  r_b;
    logic [63:0]  r_rem;

    logic [71:0]  mul_sum;
    logic [64:0]  div_rem2;
    logic [64:0]  div_diff;
    logic [65:0]  sq_rem2;
    logic [65:0]  sq_trial;
    logic [65:0]  sq_diff;

    always_comb begin
        mul_sum  = 72'(r_acc[127:64]) + 72'(r_a * r_b[7:0]);
        div_rem2 = {r_rem, r_acc[63]};
        div_diff = div_rem2 - {1'b0, r_b};
        sq_rem2  = {r_rem, r_acc[127:126]};
        sq_trial = {r_a, 2'b01};
        sq_diff  = sq_rem2 - sq_trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_op   <= AOP_MUL;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_op   <= i_op;
                unique case (i_op)
                    AOP_MUL:  r_cnt <= 6'd7;
                    AOP_DIV:  r_cnt <= 6'd63;
                    AOP_SQRT: r_cnt <= 6'd31;
                    default:  r_cnt <= 6'd0;
                endcase
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            unique case (i_op)
                AOP_MUL: begin
                    r_acc <= '0;
                    r_a   <= i_a;
                    r_b   <= i_b;
                end
                AOP_DIV: begin
                    r_acc <= {64'd0, i_a};
                    r_a   <= i_a;
                    r_b   <= i_b;
                end
                default: begin
                    r_acc <= {i_a, 64'd0};
                    r_a   <= '0;
                    r_b   <= i_b;
                end
            endcase
        end else if (r_busy) begin
            unique case (r_op)
                AOP_MUL: begin
                    r_acc <= {mul_sum, r_acc[63:8]};
                    r_b   <= r_b >> 8;
                end
                AOP_DIV: begin
                    if (!div_diff[64]) begin
                        r_rem <= div_diff[63:0];
                        r_acc <= {r_acc[127:64], r_acc[62:0], 1'b1};
                    end else begin
                        r_rem <= div_rem2[63:0];
                        r_acc <= {r_acc[127:64], r_acc[62:0], 1'b0};
                    end
                end
                default: begin
                    r_acc <= r_acc << 2;
                    if (!sq_diff[65]) begin
                        r_rem <= sq_diff[63:0];
                        r_a   <= {r_a[62:0], 1'b1};
                    end else begin
                        r_rem <= sq_rem2[63:0];
                        r_a   <= {r_a[62:0], 1'b0};
                    end
                end
            endcase
        end
    end

    always_comb begin
        unique case (r_op)
            AOP_MUL:  o_res = r_acc;
            AOP_DIV:  o_res = {64'd0, r_acc[63:0]};
            default:  o_res = {64'd0, r_a};
        endcase
    end

    assign o_done = r_done;

endmodule

`default_nettype wire

>>> rtl/psd_dp.sv
// ============================================================================
// psd_dp: datapath of the planar smooth damp block
// Configuration, spring constants, item registers, velocity and result.
// ============================================================================
`default_nettype none

module psd_dp
    import psd_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire t_cmd                  i_cmd,
    output t_status                    o_status,
    input  wire t_in_item              i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_out_item                  o_out_data
);

    logic [ST_W-1:0] r_st;
    logic [MS_W-1:0] r_ms;
    logic [TK_W-1:0] r_tk;

    logic [31:0]  r_om;
    logic [24:0]  r_x;
    logic [32:0]  r_x2;
    logic [40:0]  r_x3;
    logic [41:0]  r_den;
    logic [16:0]  r_dk;

    logic signed [WORD_BITS-1:0] r_cx, r_cy, r_tx, r_ty;
    logic signed [33:0] r_dx, r_dy;
    logic [39:0]  r_lim;
    logic [63:0]  r_lim2;
    logic [64:0]  r_len2;
    logic [31:0]  r_len;
    logic [63:0]  r_num;
    logic signed [50:0] r_a;
    logic signed [49:0] r_nx;
    logic signed [WORD_BITS-1:0] r_nvx, r_nvy, r_ox, r_oy;
    logic signed [WIDE_BITS-1:0] r_dot;

    logic signed [WORD_BITS-1:0] r_vx, r_vy;
    logic      r_ovalid;
    t_out_item r_odata;

    logic [ST_W-1:0] st_eff;
    logic [63:0]  len2_sat;
    logic         arith_done;
    logic [127:0] p;
    logic [63:0]  p_sat;
    logic         wb;
    t_aop         op;
    logic [63:0]  op_a, op_b;
    logic signed [WIDE_BITS-1:0] sum_x, sum_y, tcx, tcy, ex, ey;
    logic         snap;
    logic         cfg_hit;

    assign st_eff   = (r_st < ST_MIN) ? ST_MIN : r_st;
    assign len2_sat = r_len2[64] ? '1 : r_len2[63:0];
    assign p_sat    = (|p[127:64]) ? '1 : p[63:0];
    assign wb       = arith_done && !i_cmd.go;
    assign sum_x    = WIDE_BITS'(r_dx) + WIDE_BITS'(r_nx);
    assign sum_y    = WIDE_BITS'(r_dy) + WIDE_BITS'(r_nx);
    assign tcx      = WIDE_BITS'(r_tx) - WIDE_BITS'(r_cx);
    assign tcy      = WIDE_BITS'(r_ty) - WIDE_BITS'(r_cy);
    assign ex       = WIDE_BITS'(r_ox) - WIDE_BITS'(r_tx);
    assign ey       = WIDE_BITS'(r_oy) - WIDE_BITS'(r_ty);
    assign snap     = r_dot > 0;
    assign cfg_hit  = i_cfg_we && (i_cfg_idx == CFG_SMOOTH_TIME ||
                                   i_cfg_idx == CFG_MAX_SPEED ||
                                   i_cfg_idx == CFG_TICK_TIME);

    always_comb begin
        op   = AOP_MUL;
        op_a = '0;
        op_b = '0;
        unique case (i_cmd.step)
            P_RATE: begin
                op   = AOP_DIV;
                op_a = RATE_NUM + 64'(st_eff >> 1);
                op_b = 64'(st_eff);
            end
            P_X:    begin op_a = 64'(r_om);  op_b = 64'(r_tk); end
            P_X2:   begin op_a = 64'(r_x);   op_b = 64'(r_x);  end
            P_X3:   begin op_a = 64'(r_x2);  op_b = 64'(r_x);  end
            P_T2:   begin op_a = C2;         op_b = 64'(r_x2); end
            P_T3:   begin op_a = C3;         op_b = 64'(r_x3); end
            P_DK: begin
                op   = AOP_DIV;
                op_a = DK_NUM + 64'(r_den >> 1);
                op_b = 64'(r_den);
            end
            P_LIM:  begin op_a = 64'(r_ms);  op_b = 64'(st_eff); end
            P_LIM2: begin op_a = 64'(r_lim); op_b = 64'(r_lim);  end
            P_DX2: begin
                op_a = mag_wide(WIDE_BITS'(r_dx));
                op_b = mag_wide(WIDE_BITS'(r_dx));
            end
            P_DY2: begin
                op_a = mag_wide(WIDE_BITS'(r_dy));
                op_b = mag_wide(WIDE_BITS'(r_dy));
            end
            P_SQRT: begin op = AOP_SQRT; op_a = len2_sat; end
            P_QXM:  begin op_a = mag_wide(WIDE_BITS'(r_dx)); op_b = 64'(r_lim); end
            P_QYM:  begin op_a = mag_wide(WIDE_BITS'(r_dy)); op_b = 64'(r_lim); end
            P_QXD, P_QYD: begin
                op   = AOP_DIV;
                op_a = r_num;
                op_b = 64'(r_len);
            end
            P_OMDX: begin op_a = 64'(r_om); op_b = mag_wide(WIDE_BITS'(r_dx)); end
            P_OMDY: begin op_a = 64'(r_om); op_b = mag_wide(WIDE_BITS'(r_dy)); end
            P_NX, P_NY: begin
                op_a = mag_wide(WIDE_BITS'(r_a));
                op_b = 64'(r_tk);
            end
            P_OMNX, P_OMNY: begin
                op_a = 64'(r_om);
                op_b = mag_wide(WIDE_BITS'(r_nx));
            end
            P_VX, P_VY: begin
                op_a = mag_wide(WIDE_BITS'(r_a));
                op_b = 64'(r_dk);
            end
            P_OX:   begin op_a = mag_wide(sum_x); op_b = 64'(r_dk); end
            P_OY:   begin op_a = mag_wide(sum_y); op_b = 64'(r_dk); end
            P_DOTX: begin op_a = mag_wide(tcx);   op_b = mag_wide(ex); end
            P_DOTY: begin op_a = mag_wide(tcy);   op_b = mag_wide(ey); end
            default: begin op = AOP_MUL; end
        endcase
    end

    psd_arith u_arith (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.go),
        .i_op    (op),
        .i_a     (op_a),
        .i_b     (op_b),
        .o_done  (arith_done),
        .o_res   (p)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_RESET;
            r_ms <= MS_RESET;
            r_tk <= TK_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SMOOTH_TIME: r_st <= i_cfg_data[ST_W-1:0];
                CFG_MAX_SPEED:   r_ms <= i_cfg_data[MS_W-1:0];
                CFG_TICK_TIME:   r_tk <= i_cfg_data[TK_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_om <= '0;
            r_dk <= 17'(ONE);
        end else if (wb) begin
            unique case (i_cmd.step)
                P_RATE: r_om <= p[31:0];
                P_DK:   r_dk <= p[16:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cx <= i_in_data.current_x;
            r_cy <= i_in_data.current_y;
            r_tx <= i_in_data.target_x;
            r_ty <= i_in_data.target_y;
            r_dx <= 34'(i_in_data.current_x) - 34'(i_in_data.target_x);
            r_dy <= 34'(i_in_data.current_y) - 34'(i_in_data.target_y);
        end else if (wb) begin
            unique case (i_cmd.step)
                P_X: r_x <= (p[63:16] > 48'(X_CAP)) ? 25'(X_CAP) : p[40:16];
                P_X2: r_x2 <= p[48:16];
                P_X3: r_x3 <= p[56:16];
                P_T2: r_den <= 42'(ONE) + 42'(r_x) + 42'(p[47:16]);
                P_T3: r_den <= r_den + 42'(p[57:16]);
                P_LIM: r_lim <= p[55:16];
                P_LIM2: r_lim2 <= p_sat;
                P_DX2: r_len2 <= {1'b0, p[63:0]};
                P_DY2: r_len2 <= r_len2 + {1'b0, p[63:0]};
                P_SQRT: r_len <= p[31:0];
                P_QXM, P_QYM: r_num <= p_sat;
                P_QXD: r_dx <= 34'(apply_sign(r_dx[33], 64'(p[32:0])));
                P_QYD: r_dy <= 34'(apply_sign(r_dy[33], 64'(p[32:0])));
                P_OMDX: r_a <= 51'(WIDE_BITS'(r_vx) + apply_sign(r_dx[33], 64'(p[63:16])));
                P_OMDY: r_a <= 51'(WIDE_BITS'(r_vy) + apply_sign(r_dy[33], 64'(p[63:16])));
                P_NX, P_NY: r_nx <= 50'(apply_sign(r_a[50], 64'(p[63:16])));
                P_OMNX: r_a <= 51'(WIDE_BITS'(r_vx) - apply_sign(r_nx[49], 64'(p_sat[63:16])));
                P_OMNY: r_a <= 51'(WIDE_BITS'(r_vy) - apply_sign(r_nx[49], 64'(p_sat[63:16])));
                P_VX: r_nvx <= sat_word(apply_sign(r_a[50], 64'(p[63:16])));
                P_VY: r_nvy <= sat_word(apply_sign(r_a[50], 64'(p[63:16])));
                P_OX: r_ox <= sat_word(WIDE_BITS'(r_cx) - WIDE_BITS'(r_dx)
                                       + apply_sign(sum_x[WIDE_BITS-1], 64'(p[63:16])));
                P_OY: r_oy <= sat_word(WIDE_BITS'(r_cy) - WIDE_BITS'(r_dy)
                                       + apply_sign(sum_y[WIDE_BITS-1], 64'(p[63:16])));
                P_DOTX: r_dot <= apply_sign(tcx[WIDE_BITS-1] ^ ex[WIDE_BITS-1], p[63:0]);
                P_DOTY: r_dot <= r_dot
                                 + apply_sign(tcy[WIDE_BITS-1] ^ ey[WIDE_BITS-1], p[63:0]);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_vx     <= '0;
            r_vy     <= '0;
        end else if (i_cmd.commit) begin
            r_ovalid <= 1'b1;
            r_vx     <= snap ? '0 : r_nvx;
            r_vy     <= snap ? '0 : r_nvy;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_odata.next_x <= snap ? r_tx : r_ox;
            r_odata.next_y <= snap ? r_ty : r_oy;
        end
    end

    assign o_status.done     = arith_done;
    assign o_status.clamp    = len2_sat > r_lim2;
    assign o_status.cfg_hit  = cfg_hit;
    assign o_status.out_busy = r_ovalid && !i_out_ready;
    assign o_out_valid       = r_ovalid;
    assign o_out_data        = r_odata;

    a_commit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> r_ovalid)
        else $error("result not presented after commit");

    a_rise_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(i_cmd.commit))
        else $error("result appeared without commit");

    a_snap_vel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && snap) |=> (r_vx == 0 && r_vy == 0))
        else $error("velocity not cleared on overshoot");

    a_dk_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wb && i_cmd.step == P_DK) |=> (r_dk <= 17'(ONE)))
        else $error("decay factor above one");

endmodule

`default_nettype wire

>>> rtl/psd_ctrl.sv
// ============================================================================
// psd_ctrl: controller of the planar smooth damp block
// Steps the datapath through constant derivation and the per item update.
// ============================================================================
`default_nettype none

module psd_ctrl
    import psd_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    typedef enum logic [1:0] {
        ST_CALC,
        ST_IDLE,
        ST_FIN
    } t_state;

    t_state r_state;
    t_step  r_step;
    logic   r_go;
    logic   in_fire;

    assign o_in_ready   = (r_state == ST_IDLE) && !i_status.cfg_hit;
    assign in_fire      = o_in_ready && i_in_valid;
    assign o_cmd.go     = r_go;
    assign o_cmd.step   = r_step;
    assign o_cmd.load   = in_fire;
    assign o_cmd.commit = (r_state == ST_FIN) && !i_status.out_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CALC;
            r_step  <= P_RATE;
            r_go    <= 1'b1;
        end else begin
            r_go <= 1'b0;
            if (i_status.cfg_hit) begin
                r_state <= ST_CALC;
                r_step  <= P_RATE;
                r_go    <= 1'b1;
            end else begin
                unique case (r_state)
                    ST_IDLE: begin
                        if (in_fire) begin
                            r_state <= ST_CALC;
                            r_step  <= P_LIM;
                            r_go    <= 1'b1;
                        end
                    end
                    ST_CALC: begin
                        if (r_go && r_step == P_SQRT && !i_status.clamp) begin
                            r_step <= P_OMDX;
                            r_go   <= 1'b1;
                        end else if (i_status.done && !r_go) begin
                            if (r_step == P_DK) begin
                                r_state <= ST_IDLE;
                            end else if (r_step == P_DOTY) begin
                                r_state <= ST_FIN;
                            end else begin
                                r_step <= t_step'(r_step + 5'd1);
                                r_go   <= 1'b1;
                            end
                        end
                    end
                    ST_FIN: begin
                        if (!i_status.out_busy) begin
                            r_state <= ST_IDLE;
                        end
                    end
                    default: r_state <= ST_IDLE;
                endcase
            end
        end
    end

endmodule

`default_nettype wire
